[rtl/ltri_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltri_pkg
// Shared types, widths and helpers for the linear triangle evaluator.
// ----------------------------------------------------------------------------
package ltri_pkg;

    // Magnitude of the Jacobian determinant, divider remainder and quotient.
    localparam int DW = 66;
    localparam int RW = 98;
    localparam int QW = 32;
    localparam int NL = 6;

    // Result status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_OOB   = 2'd1;
    localparam logic [1:0] ST_DEGEN = 2'd2;

    // Result fields that ride along the divider chain unchanged.
    typedef struct packed {
        logic [31:0] global_x;
        logic [31:0] global_y;
        logic [31:0] shape0;
        logic [31:0] shape1;
        logic [31:0] shape2;
        logic [1:0]  status;
    } t_pass;

    // One item in flight through the divider cells.
    typedef struct packed {
        logic                   valid;
        logic [DW-1:0]          den;
        logic [NL-1:0][RW-1:0]  rem;
        logic [NL-1:0][QW-1:0]  quo;
        logic [NL-1:0]          neg;
        logic [NL-1:0]          ovf;
        t_pass                  pass;
    } t_div;

    // Saturate a 68-bit signed value to the signed 32-bit range.
    function automatic logic [31:0] sat32(input logic [67:0] v);
        logic [36:0] up;
        up = v[67:31];
        if (up == '0 || up == '1) begin
            return v[31:0];
        end else if (v[67]) begin
            return 32'h8000_0000;
        end else begin
            return 32'h7FFF_FFFF;
        end
    endfunction

endpackage

[rtl/ltri_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltri_front
// Front pipeline: bounds check, shape values, products, Jacobian determinant,
// global position and the setup of six gradient divisions.
// ----------------------------------------------------------------------------
module ltri_front
    import ltri_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  logic [31:0] i_node0_x,
    input  logic [31:0] i_node0_y,
    input  logic [31:0] i_node1_x,
    input  logic [31:0] i_node1_y,
    input  logic [31:0] i_node2_x,
    input  logic [31:0] i_node2_y,
    input  logic [31:0] i_xi,
    input  logic [31:0] i_eta,
    output t_div        o_div
);

    localparam logic signed [33:0] ONE = 34'sh1 << FRAC_BITS;

    // Stage 0: shape values, bounds check and Jacobian entries.
    logic signed [33:0] w_xi, w_eta, w_s0;
    logic signed [32:0] w_x0, w_x1, w_x2, w_y0, w_y1, w_y2;
    logic signed [32:0] w_a, w_b, w_c, w_d;
    logic signed [32:0] w_n [NL];
    logic               w_oob;

    assign w_xi  = $signed({{2{i_xi[31]}}, i_xi});
    assign w_eta = $signed({{2{i_eta[31]}}, i_eta});
    assign w_s0  = ONE - w_xi - w_eta;
    assign w_x0  = $signed({i_node0_x[31], i_node0_x});
    assign w_x1  = $signed({i_node1_x[31], i_node1_x});
    assign w_x2  = $signed({i_node2_x[31], i_node2_x});
    assign w_y0  = $signed({i_node0_y[31], i_node0_y});
    assign w_y1  = $signed({i_node1_y[31], i_node1_y});
    assign w_y2  = $signed({i_node2_y[31], i_node2_y});
    assign w_a   = w_x1 - w_x0;
    assign w_b   = w_x2 - w_x0;
    assign w_c   = w_y1 - w_y0;
    assign w_d   = w_y2 - w_y0;
    assign w_oob = (w_xi > ONE) || (w_xi < -ONE) || (w_eta > ONE) || (w_eta < -ONE)
                || (w_s0 < 0);

    // Gradient numerators, in output order.
    assign w_n[0] = w_y1 - w_y2;
    assign w_n[1] = w_x2 - w_x1;
    assign w_n[2] = w_d;
    assign w_n[3] = -w_b;
    assign w_n[4] = -w_c;
    assign w_n[5] = w_a;

    // Stage 1 registers.
    logic                     r1_valid, r1_oob;
    logic signed [33:0]       r1_coef [3];
    logic signed [31:0]       r1_x [3];
    logic signed [31:0]       r1_y [3];
    logic signed [32:0]       r1_a, r1_b, r1_c, r1_d;
    logic [NL-1:0][31:0]      r1_mag;
    logic [NL-1:0]            r1_nneg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
        end
        if (i_en) begin
            r1_oob     <= w_oob;
            r1_coef[0] <= w_s0;
            r1_coef[1] <= w_xi;
            r1_coef[2] <= w_eta;
            r1_x[0]    <= i_node0_x;
            r1_x[1]    <= i_node1_x;
            r1_x[2]    <= i_node2_x;
            r1_y[0]    <= i_node0_y;
            r1_y[1]    <= i_node1_y;
            r1_y[2]    <= i_node2_y;
            r1_a       <= w_a;
            r1_b       <= w_b;
            r1_c       <= w_c;
            r1_d       <= w_d;
            for (int k = 0; k < NL; k++) begin
                r1_nneg[k] <= w_n[k][32];
                r1_mag[k]  <= w_n[k][32] ? 32'(-w_n[k]) : w_n[k][31:0];
            end
        end
    end

    // Stage 2: one multiplier per product.
    logic                     r2_valid, r2_oob;
    logic signed [65:0]       r2_px [3];
    logic signed [65:0]       r2_py [3];
    logic signed [65:0]       r2_ad, r2_bc;
    logic signed [33:0]       r2_s0;
    logic [31:0]              r2_xi, r2_eta;
    logic [NL-1:0][31:0]      r2_mag;
    logic [NL-1:0]            r2_nneg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (i_en) begin
            r2_valid <= r1_valid;
        end
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r2_px[k] <= r1_coef[k] * r1_x[k];
                r2_py[k] <= r1_coef[k] * r1_y[k];
            end
            r2_ad   <= r1_a * r1_d;
            r2_bc   <= r1_b * r1_c;
            r2_oob  <= r1_oob;
            r2_s0   <= r1_coef[0];
            r2_xi   <= r1_coef[1][31:0];
            r2_eta  <= r1_coef[2][31:0];
            r2_mag  <= r1_mag;
            r2_nneg <= r1_nneg;
        end
    end

    // Stage 3: product sums and the determinant.
    logic                     r3_valid, r3_oob;
    logic signed [67:0]       r3_accx, r3_accy;
    logic signed [66:0]       r3_det;
    logic signed [33:0]       r3_s0;
    logic [31:0]              r3_xi, r3_eta;
    logic [NL-1:0][31:0]      r3_mag;
    logic [NL-1:0]            r3_nneg;

    function automatic logic signed [67:0] sx68(input logic signed [65:0] v);
        return $signed({{2{v[65]}}, v});
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (i_en) begin
            r3_valid <= r2_valid;
        end
        if (i_en) begin
            r3_accx <= sx68(r2_px[0]) + sx68(r2_px[1]) + sx68(r2_px[2]);
            r3_accy <= sx68(r2_py[0]) + sx68(r2_py[1]) + sx68(r2_py[2]);
            r3_det  <= $signed({r2_ad[65], r2_ad}) - $signed({r2_bc[65], r2_bc});
            r3_oob  <= r2_oob;
            r3_s0   <= r2_s0;
            r3_xi   <= r2_xi;
            r3_eta  <= r2_eta;
            r3_mag  <= r2_mag;
            r3_nneg <= r2_nneg;
        end
    end

    // Stage 4: saturation, status and divider operands.
    logic signed [67:0] w_shx, w_shy;
    logic [66:0]        w_dabs;
    logic               w_dzero;
    t_div               n4, r4;

    assign w_shx   = r3_accx >>> FRAC_BITS;
    assign w_shy   = r3_accy >>> FRAC_BITS;
    assign w_dzero = (r3_det == '0);
    assign w_dabs  = r3_det[66] ? 67'(-r3_det) : r3_det;

    always_comb begin
        n4       = '0;
        n4.valid = r3_valid;
        n4.den   = w_dzero ? DW'(1) : w_dabs[DW-1:0];
        for (int k = 0; k < NL; k++) begin
            n4.rem[k] = RW'(r3_mag[k]) << (2 * FRAC_BITS);
            n4.neg[k] = r3_nneg[k] ^ r3_det[66];
        end
        if (r3_oob) begin
            n4.pass.status = ST_OOB;
        end else begin
            n4.pass.global_x = sat32(w_shx);
            n4.pass.global_y = sat32(w_shy);
            n4.pass.shape0   = sat32({{34{r3_s0[33]}}, r3_s0});
            n4.pass.shape1   = r3_xi;
            n4.pass.shape2   = r3_eta;
            n4.pass.status   = w_dzero ? ST_DEGEN : ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4.valid <= 1'b0;
        end else if (i_en) begin
            r4 <= n4;
        end
    end

    // Stage 5: quotients that need more than 32 bits saturate.
    t_div n5, r5;

    always_comb begin
        n5 = r4;
        for (int k = 0; k < NL; k++) begin
            n5.ovf[k] = (r4.rem[k] >= (RW'(r4.den) << QW));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5.valid <= 1'b0;
        end else if (i_en) begin
            r5 <= n5;
        end
    end

    assign o_div = r5;

endmodule

[rtl/ltri_div_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltri_div_cell
// One restoring-division cell: decides one quotient bit for all six
// gradient lanes and hands the item to the next cell.
// ----------------------------------------------------------------------------
module ltri_div_cell
    import ltri_pkg::*;
#(
    parameter int BIT = 0
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  t_div i_d,
    output t_div o_d
);

    logic [RW-1:0] w_dsh;
    t_div          n_d, r_d;

    assign w_dsh = RW'(i_d.den) << BIT;

    // Subtract the shifted divisor where it fits.
    always_comb begin
        n_d = i_d;
        for (int k = 0; k < NL; k++) begin
            if (i_d.rem[k] >= w_dsh) begin
                n_d.rem[k]      = i_d.rem[k] - w_dsh;
                n_d.quo[k][BIT] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d.valid <= 1'b0;
        end else if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;

endmodule

[rtl/linear_triangle_element_eval_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_triangle_element_eval_core
// Evaluates a linear three-node triangle at one natural point: global
// position, shape values and global shape gradients.
//
//   Channel | Direction | Handshake               | Payload
//   --------+-----------+-------------------------+---------------------------
//   in      | input     | i_in_valid / o_in_ready | node coords, xi, eta
//   out     | output    | o_out_valid/i_out_ready | position, shapes, grads,
//           |           |                         | status
//
// One item per cycle while the output is taken; the pipeline holds five
// front stages, one divider cell per quotient bit (32) and the output register.
// Reset is synchronous, active low, and clears only the valid bits.
// The whole pipeline advances together; it holds while the output
// register is full and not taken.
// ----------------------------------------------------------------------------
module linear_triangle_element_eval_core
    import ltri_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [31:0] i_node0_x,
    input  logic [31:0] i_node0_y,
    input  logic [31:0] i_node1_x,
    input  logic [31:0] i_node1_y,
    input  logic [31:0] i_node2_x,
    input  logic [31:0] i_node2_y,
    input  logic [31:0] i_xi,
    input  logic [31:0] i_eta,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_global_x,
    output logic [31:0] o_global_y,
    output logic [31:0] o_shape0,
    output logic [31:0] o_shape1,
    output logic [31:0] o_shape2,
    output logic [31:0] o_grad0_x,
    output logic [31:0] o_grad0_y,
    output logic [31:0] o_grad1_x,
    output logic [31:0] o_grad1_y,
    output logic [31:0] o_grad2_x,
    output logic [31:0] o_grad2_y,
    output logic [1:0]  o_status
);

    localparam logic signed [31:0] ONE32 = 32'sh1 << FRAC_BITS;

    logic w_en;
    logic r_out_valid;
    t_div w_chain [QW+1];

    assign w_en       = !r_out_valid || i_out_ready;
    assign o_in_ready = w_en;

    // Front pipeline.
    ltri_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en),
        .i_valid   (i_in_valid),
        .i_node0_x (i_node0_x),
        .i_node0_y (i_node0_y),
        .i_node1_x (i_node1_x),
        .i_node1_y (i_node1_y),
        .i_node2_x (i_node2_x),
        .i_node2_y (i_node2_y),
        .i_xi      (i_xi),
        .i_eta     (i_eta),
        .o_div     (w_chain[0])
    );

    // Divider chain, most significant quotient bit first.
    for (genvar j = 0; j < QW; j++) begin : g_cell
        ltri_div_cell #(
            .BIT (QW - 1 - j)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_d     (w_chain[j]),
            .o_d     (w_chain[j+1])
        );
    end

    // Sign, saturation and zeroing of the gradients.
    t_div                w_last;
    logic [NL-1:0][31:0] n_grad, r_grad;
    t_pass               r_pass;

    assign w_last = w_chain[QW];

    always_comb begin
        for (int k = 0; k < NL; k++) begin
            if (w_last.pass.status != ST_OK) begin
                n_grad[k] = '0;
            end else if (w_last.ovf[k]) begin
                n_grad[k] = w_last.neg[k] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            end else if (w_last.neg[k]) begin
                n_grad[k] = (w_last.quo[k] > 32'h8000_0000) ? 32'h8000_0000
                                                           : (~w_last.quo[k] + 32'd1);
            end else begin
                n_grad[k] = w_last.quo[k][31] ? 32'h7FFF_FFFF : w_last.quo[k];
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_last.valid;
        end
        if (w_en) begin
            r_grad <= n_grad;
            r_pass <= w_last.pass;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_global_x  = r_pass.global_x;
    assign o_global_y  = r_pass.global_y;
    assign o_shape0    = r_pass.shape0;
    assign o_shape1    = r_pass.shape1;
    assign o_shape2    = r_pass.shape2;
    assign o_status    = r_pass.status;
    assign o_grad0_x   = r_grad[0];
    assign o_grad0_y   = r_grad[1];
    assign o_grad1_x   = r_grad[2];
    assign o_grad1_y   = r_grad[3];
    assign o_grad2_x   = r_grad[4];
    assign o_grad2_y   = r_grad[5];

    // A point outside the element yields zero position, shape values and gradients.
    a_oob_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_OOB) |->
        (o_global_x == '0 && o_global_y == '0 && o_shape0 == '0 && o_shape1 == '0
         && o_shape2 == '0 && o_grad0_x == '0 && o_grad2_y == '0))
        else $error("out-of-bounds result carries nonzero fields");

    // A degenerate element gives zero gradients.
    a_degen_grad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_DEGEN) |->
        (o_grad0_x == '0 && o_grad0_y == '0 && o_grad1_x == '0 && o_grad1_y == '0
         && o_grad2_x == '0 && o_grad2_y == '0))
        else $error("degenerate result carries nonzero gradients");

    // An accepted point lies within the natural bounds.
    a_xi_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_OOB) |->
        ($signed(o_shape1) <= ONE32 && $signed(o_shape1) >= -ONE32
         && $signed(o_shape2) <= ONE32 && $signed(o_shape2) >= -ONE32))
        else $error("in-bounds result with natural coordinate out of range");

    // The status code is never the unused value.
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status == ST_OK || o_status == ST_OOB || o_status == ST_DEGEN))
        else $error("invalid status code");

endmodule

[sim/linear_triangle_element_eval_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_triangle_element_eval_core_tb
// Self-checking bench for the linear triangle evaluator. A table of directed
// elements and points is followed by random ones, most of them inside the
// element. Every result is checked field by field against a behavioral model
// of the position, shape values and gradients, with random idling on both
// channels and one long output stall.
// ----------------------------------------------------------------------------
module linear_triangle_element_eval_core_tb;
    import ltri_pkg::*;

    localparam int FRAC = 16;
    localparam int LATENCY = 38;
    localparam int N_RANDOM = 830;
    localparam logic [31:0] ONE = 32'h0001_0000;

    // One element and evaluation point.
    typedef struct {
        logic [31:0] x0, y0, x1, y1, x2, y2, xi, eta;
    } t_point;

    // One evaluation result.
    typedef struct packed {
        logic [31:0] gx, gy, s0, s1, s2;
        logic [31:0] g0x, g0y, g1x, g1y, g2x, g2y;
        logic [1:0]  status;
    } t_eval;

    // Directed row: a point, and an optional typed-in status.
    typedef struct {
        t_point pt;
        logic   has_status;
        logic [1:0] status;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [31:0] i_node0_x = '0, i_node0_y = '0, i_node1_x = '0, i_node1_y = '0;
    logic [31:0] i_node2_x = '0, i_node2_y = '0, i_xi = '0, i_eta = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [31:0] o_global_x, o_global_y, o_shape0, o_shape1, o_shape2;
    logic [31:0] o_grad0_x, o_grad0_y, o_grad1_x, o_grad1_y, o_grad2_x, o_grad2_y;
    logic [1:0]  o_status;

    t_eval expected_evals[$];
    int    n_errors = 0;
    int    n_checked = 0;
    int    n_oob = 0, n_degen = 0;
    logic  stim_done = 1'b0;
    logic  hold_off = 1'b0;

    linear_triangle_element_eval_core dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Saturate an exact value to the signed 32-bit range.
    function automatic logic [31:0] clamp32(input logic signed [159:0] v);
        if (v > 160'sh7FFF_FFFF) return 32'h7FFF_FFFF;
        if (v < -160'sh8000_0000) return 32'h8000_0000;
        return v[31:0];
    endfunction

    // Gradient term: num * 2^(2F) / det, truncated toward zero, saturated.
    function automatic logic [31:0] grad_term(input logic signed [159:0] num,
                                              input logic signed [159:0] det);
        logic signed [159:0] q;
        q = (num <<< (2 * FRAC)) / det;
        return clamp32(q);
    endfunction

    // Behavioral evaluation of the element at the point.
    function automatic t_eval eval_triangle(input t_point p);
        t_eval r;
        logic signed [159:0] x0, y0, x1, y1, x2, y2, xi, eta, one, s0;
        logic signed [159:0] a, b, c, d, det;
        x0 = $signed(p.x0); y0 = $signed(p.y0);
        x1 = $signed(p.x1); y1 = $signed(p.y1);
        x2 = $signed(p.x2); y2 = $signed(p.y2);
        xi = $signed(p.xi); eta = $signed(p.eta);
        one = 160'sd1 <<< FRAC;
        s0 = one - xi - eta;
        r = '0;
        if (xi > one || xi < -one || eta > one || eta < -one || s0 < 0) begin
            r.status = ST_OOB;
            return r;
        end
        r.gx = clamp32((s0 * x0 + xi * x1 + eta * x2) >>> FRAC);
        r.gy = clamp32((s0 * y0 + xi * y1 + eta * y2) >>> FRAC);
        r.s0 = clamp32(s0);
        r.s1 = p.xi;
        r.s2 = p.eta;
        a = x1 - x0; b = x2 - x0; c = y1 - y0; d = y2 - y0;
        det = a * d - b * c;
        if (det == 0) begin
            r.status = ST_DEGEN;
            return r;
        end
        r.g0x = grad_term(y1 - y2, det);
        r.g0y = grad_term(x2 - x1, det);
        r.g1x = grad_term(d, det);
        r.g1y = grad_term(-b, det);
        r.g2x = grad_term(-c, det);
        r.g2y = grad_term(a, det);
        r.status = ST_OK;
        return r;
    endfunction

    // Random point: mostly inside, sometimes on edges, sometimes anywhere.
    function automatic t_point random_point();
        t_point p;
        int unsigned sel;
        int signed xi_v, eta_v;
        sel = $urandom_range(0, 99);
        p.x0 = $urandom; p.y0 = $urandom; p.x1 = $urandom;
        p.y1 = $urandom; p.x2 = $urandom; p.y2 = $urandom;
        if (sel < 40) begin
            // Small, well-scaled elements.
            p.x0 = $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
            p.y0 = $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
            p.x1 = p.x0 + $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
            p.y1 = p.y0 + $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
            p.x2 = p.x0 + $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
            p.y2 = p.y0 + $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
        end else if (sel < 48) begin
            // Collinear nodes give a zero determinant.
            p.x1 = p.x0 + 32'h0001_0000; p.y1 = p.y0 + 32'h0002_0000;
            p.x2 = p.x0 + 32'h0003_0000; p.y2 = p.y0 + 32'h0006_0000;
        end
        if (sel < 85) begin
            xi_v = $urandom_range(0, 32'h0002_0000) - 32'h0001_0000;
            eta_v = $urandom_range(0, 32'h0002_0000) - 32'h0001_0000;
            if (xi_v + eta_v > 32'sh0001_0000) eta_v = 32'sh0001_0000 - xi_v;
            if (eta_v < -32'sh0001_0000) eta_v = -32'sh0001_0000;
            if ($urandom_range(0, 9) == 0) eta_v = 32'sh0001_0000 - xi_v;
            p.xi = xi_v; p.eta = eta_v;
        end else begin
            p.xi = $urandom; p.eta = $urandom;
        end
        return p;
    endfunction

    // Directed table: extremes, boundaries, degenerate and out-of-bounds.
    function automatic t_row mk(input logic [31:0] x0, y0, x1, y1, x2, y2, xi, eta,
                                input logic hs, input logic [1:0] st);
        t_row r;
        r.pt = '{x0, y0, x1, y1, x2, y2, xi, eta};
        r.has_status = hs;
        r.status = st;
        return r;
    endfunction

    t_row directed_rows[$];

    initial begin
        directed_rows = '{
            mk(0, 0, ONE, 0, 0, ONE, 0, 0, 1'b1, ST_OK),
            mk(0, 0, ONE, 0, 0, ONE, ONE, 0, 1'b1, ST_OK),
            mk(0, 0, ONE, 0, 0, ONE, 0, ONE, 1'b1, ST_OK),
            mk(0, 0, ONE, 0, 0, ONE, -ONE, -ONE, 1'b1, ST_OK),
            mk(0, 0, ONE, 0, 0, ONE, ONE + 1, 0, 1'b1, ST_OOB),
            mk(0, 0, ONE, 0, 0, ONE, -ONE - 1, 0, 1'b1, ST_OOB),
            mk(0, 0, ONE, 0, 0, ONE, 0, ONE + 1, 1'b1, ST_OOB),
            mk(0, 0, ONE, 0, 0, ONE, 0, -ONE - 1, 1'b1, ST_OOB),
            mk(0, 0, ONE, 0, 0, ONE, 32'h8000, 32'h8001, 1'b1, ST_OOB),
            mk(0, 0, ONE, 0, 0, ONE, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, ST_OOB),
            mk(0, 0, 0, 0, 0, 0, 32'h4000, 32'h4000, 1'b1, ST_DEGEN),
            mk(ONE, ONE, 2 * ONE, 2 * ONE, 3 * ONE, 3 * ONE, 0, 0, 1'b1, ST_DEGEN),
            mk(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
               32'h7FFF_FFFF, 32'h8000_0000, -ONE, -ONE, 1'b0, ST_OK),
            mk(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
               32'h8000_0000, 32'h7FFF_FFFF, -ONE, ONE, 1'b0, ST_OK),
            mk(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
               32'h8000_0000, 32'h8000_0000, ONE, -ONE, 1'b0, ST_OK),
            mk(0, 0, 1, 0, 0, 1, 32'h5555, 32'h5555, 1'b0, ST_OK),
            mk(0, 0, 32'h7FFF_FFFF, 0, 0, 32'h7FFF_FFFF, 32'h1234, 32'h4321, 1'b0, ST_OK),
            mk(32'hFFFF_0000, 32'h0003_0000, 32'h0005_8000, 32'hFFFE_0000,
               32'h0002_0000, 32'h0007_0000, 32'hFFFF_C000, 32'h0000_8000, 1'b0, ST_OK),
            mk(0, 0, 0, 1, 1, 0, 0, 0, 1'b0, ST_OK),
            mk(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
               32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, ST_DEGEN)
        };
    end

    // Offer one point and wait for its transfer.
    task automatic send_point(input t_point p, input logic hs, input logic [1:0] st);
        t_eval e;
        if ($urandom_range(0, 99) < 16 && !hold_off) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(0, 99) < 16 && !hold_off) @(posedge i_clk);
        end
        e = eval_triangle(p);
        if (hs && e.status != st) begin
            $display("%0t: table status %0d, model gives %0d", $time, st, e.status);
            n_errors++;
        end
        i_node0_x <= p.x0; i_node0_y <= p.y0; i_node1_x <= p.x1;
        i_node1_y <= p.y1; i_node2_x <= p.x2; i_node2_y <= p.y2;
        i_xi <= p.xi; i_eta <= p.eta;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        expected_evals.push_back(e);
        if (e.status == ST_OOB) n_oob++;
        if (e.status == ST_DEGEN) n_degen++;
    endtask

    // Stimulus: table first, then random points.
    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (directed_rows[k])
            send_point(directed_rows[k].pt, directed_rows[k].has_status,
                       directed_rows[k].status);
        for (int k = 0; k < N_RANDOM; k++)
            send_point(random_point(), 1'b0, ST_OK);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        stim_done <= 1'b1;
    end

    // Receiver: random stalls, one long hold-off, calm stretch near the middle.
    initial begin
        int cyc;
        cyc = 0;
        forever begin
            @(posedge i_clk);
            cyc++;
            if (cyc >= 400 && cyc < 600) begin
                hold_off <= 1'b1;
                i_out_ready <= 1'b0;
            end else begin
                hold_off <= 1'b0;
                if (cyc >= 700 && cyc < 900) i_out_ready <= 1'b1;
                else i_out_ready <= ($urandom_range(0, 99) >= 16);
            end
        end
    end

    // Compare each result transfer with the oldest expectation.
    always @(posedge i_clk) begin
        t_eval e;
        t_eval got;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = '{o_global_x, o_global_y, o_shape0, o_shape1, o_shape2,
                    o_grad0_x, o_grad0_y, o_grad1_x, o_grad1_y, o_grad2_x,
                    o_grad2_y, o_status};
            if (expected_evals.size() == 0) begin
                $display("%0t: result with none expected", $time);
                n_errors++;
            end else begin
                e = expected_evals.pop_front();
                n_checked++;
                if (got != e) begin
                    n_errors++;
                    $display("%0t: mismatch expected pos %h %h shp %h %h %h st %0d",
                             $time, e.gx, e.gy, e.s0, e.s1, e.s2, e.status);
                    $display("    grads %h %h %h %h %h %h", e.g0x, e.g0y, e.g1x,
                             e.g1y, e.g2x, e.g2y);
                    $display("  actual pos %h %h shp %h %h %h st %0d",
                             got.gx, got.gy, got.s0, got.s1, got.s2, got.status);
                    $display("    grads %h %h %h %h %h %h", got.g0x, got.g0y,
                             got.g1x, got.g1y, got.g2x, got.g2y);
                end
            end
        end
    end

    // End of run once every result has come back.
    initial begin
        wait (stim_done);
        while (expected_evals.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        $display("Checked %0d results, %0d outside the element, %0d degenerate,",
                 n_checked, n_oob, n_degen);
        $display("with random idling and a long output stall; %0d errors.", n_errors);
        if (n_errors == 0) begin
            $display("linear_triangle_element_eval_core_tb passed");
        end else begin
            $display("linear_triangle_element_eval_core_tb failed");
        end
        $finish;
    end

    // Timeout guard.
    initial begin
        #2_000_000;
        $display("linear_triangle_element_eval_core_tb failed");
        $finish;
    end

endmodule
